// ===== hdl/dle_byte_stuffing_framer_bcc_unit_assert.svh =====
// Assertion macros for the framer checker.
`ifndef DLE_BYTE_STUFFING_FRAMER_BCC_UNIT_ASSERT_SVH
`define DLE_BYTE_STUFFING_FRAMER_BCC_UNIT_ASSERT_SVH

// Checked outside reset.
`define DBSF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

// Checked on every edge, reset included.
`define DBSF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

// ===== hdl/dbsf_pkg.sv =====
package dbsf_pkg;

  localparam logic [7:0] CHR_DLE = 8'h10;
  localparam logic [7:0] CHR_STX = 8'h02;
  localparam logic [7:0] CHR_ETX = 8'h03;

  localparam int DBSF_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       open;
    logic       dle;
    logic       last;
    logic [7:0] bcc;
  } dbsf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dbsf_q_status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN_DLE,
    PH_OPEN_STX,
    PH_STUFF,
    PH_DATA,
    PH_CLOSE_DLE,
    PH_CLOSE_ETX,
    PH_BCC
  } phase_t;

endpackage

// ===== hdl/dbsf_front.sv =====
module dbsf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_valid,
  output logic                       s_ready,
  input  logic [7:0]                 s_data,
  input  logic                       s_last,
  input  dbsf_pkg::dbsf_q_status_t   q_status,
  output logic                       push,
  output dbsf_pkg::dbsf_cmd_t        push_cmd
);
  import dbsf_pkg::*;

  logic       frame_open;
  logic       frame_open_next;
  logic [7:0] check_accum;
  logic [7:0] check_accum_next;
  logic [7:0] sum;

  assign s_ready = !q_status.full;
  assign push    = s_valid && s_ready;

  always_comb begin
    sum = (frame_open ? check_accum : 8'h00) ^ s_data;
    push_cmd.data = s_data;
    push_cmd.open = !frame_open;
    push_cmd.dle  = (s_data == CHR_DLE);
    push_cmd.last = s_last;
    push_cmd.bcc  = sum ^ CHR_ETX;
    frame_open_next  = frame_open;
    check_accum_next = check_accum;
    if (push) begin
      frame_open_next  = !s_last;
      check_accum_next = s_last ? 8'h00 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      check_accum <= 8'h00;
    end else begin
      frame_open  <= frame_open_next;
      check_accum <= check_accum_next;
    end
  end

endmodule

// ===== hdl/dbsf_queue.sv =====
module dbsf_queue #(
  parameter int DEPTH = dbsf_pkg::DBSF_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  dbsf_pkg::dbsf_cmd_t        push_cmd,
  input  logic                       pop,
  output dbsf_pkg::dbsf_cmd_t        head,
  output dbsf_pkg::dbsf_q_status_t   status
);
  import dbsf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbsf_cmd_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dbsf_back.sv =====
module dbsf_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dbsf_pkg::dbsf_cmd_t        head,
  input  dbsf_pkg::dbsf_q_status_t   q_status,
  output logic                       pop,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic [7:0]                 m_data,
  output logic                       m_last,
  output logic                       m_eof
);
  import dbsf_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  dbsf_cmd_t  cmd;
  logic       advance;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_run_end;
  logic       emit_eof;

  function automatic phase_t start_phase(input dbsf_cmd_t c);
    if (c.open) begin
      return PH_OPEN_DLE;
    end
    return c.dle ? PH_STUFF : PH_DATA;
  endfunction

  assign advance = !m_valid || m_ready;
  assign emit    = (phase != PH_IDLE) && advance;

  // byte and flags for the current phase
  always_comb begin
    emit_byte    = cmd.data;
    emit_run_end = 1'b0;
    emit_eof     = 1'b0;
    case (phase)
      PH_OPEN_DLE:  emit_byte = CHR_DLE;
      PH_OPEN_STX:  emit_byte = CHR_STX;
      PH_STUFF:     emit_byte = CHR_DLE;
      PH_DATA: begin
        emit_byte    = cmd.data;
        emit_run_end = !cmd.last;
      end
      PH_CLOSE_DLE: emit_byte = CHR_DLE;
      PH_CLOSE_ETX: emit_byte = CHR_ETX;
      PH_BCC: begin
        emit_byte    = cmd.bcc;
        emit_run_end = 1'b1;
        emit_eof     = 1'b1;
      end
      default:      emit_byte = cmd.data;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    phase_next = phase;
    if (phase == PH_IDLE) begin
      if (!q_status.empty) begin
        pop        = 1'b1;
        phase_next = start_phase(head);
      end
    end else if (advance) begin
      if (emit_run_end) begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          phase_next = start_phase(head);
        end else begin
          phase_next = PH_IDLE;
        end
      end else begin
        case (phase)
          PH_OPEN_DLE:  phase_next = PH_OPEN_STX;
          PH_OPEN_STX:  phase_next = cmd.dle ? PH_STUFF : PH_DATA;
          PH_STUFF:     phase_next = PH_DATA;
          PH_DATA:      phase_next = PH_CLOSE_DLE;
          PH_CLOSE_DLE: phase_next = PH_CLOSE_ETX;
          PH_CLOSE_ETX: phase_next = PH_BCC;
          default:      phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      m_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (emit) begin
      m_data <= emit_byte;
      m_last <= emit_run_end;
      m_eof  <= emit_eof;
    end
  end

endmodule

// ===== hdl/dle_byte_stuffing_framer_bcc_unit.sv =====
// DLE/STX/ETX byte-stuffing framer with XOR check byte.
// Input stream: s_axis_tdata carries one payload byte, s_axis_tlast marks
// the final payload byte of a frame. Output stream: m_axis_tdata carries one
// line byte, m_axis_tlast closes the run of bytes for one input transfer,
// m_axis_tuser flags the check byte that ends a frame.
// A frame opens with DLE STX, a DLE payload byte goes out twice, and the
// frame closes with DLE ETX and the XOR of all payload bytes and ETX.
// The front end tracks frame state and the running check and queues one
// command per input; the back end sequences the line bytes, one per cycle while the receiver takes them.
// Each input byte yields one to seven line bytes (typically one inside a
// frame); the back-end output register sets the pace. An input byte passes
// through the queue, the phase register and the output register on its way out.
// With QUEUE_DEPTH commands buffered the input keeps accepting while the
// back end works through earlier bytes.
// Reset clears frame state, the check, the queue and the output valid.
// When the receiver stalls the output transfer holds, the back end stops,
// and the input stalls once the queue is full; nothing is dropped.
module dle_byte_stuffing_framer_bcc_unit #(
  parameter int QUEUE_DEPTH = dbsf_pkg::DBSF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
  input  logic       s_axis_tlast,   // last_in_frame
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] line_byte
  output logic       m_axis_tlast,   // end_of_run
  output logic       m_axis_tuser    // end_of_frame
);
  import dbsf_pkg::*;

  dbsf_q_status_t q_status;
  dbsf_cmd_t      push_cmd;
  dbsf_cmd_t      head;
  logic           push;
  logic           pop;

  dbsf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_data   (s_axis_tdata),
    .s_last   (s_axis_tlast),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dbsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  dbsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (m_axis_tdata),
    .m_last   (m_axis_tlast),
    .m_eof    (m_axis_tuser)
  );

endmodule

// ===== hdl/dbsf_checker.sv =====
`include "dle_byte_stuffing_framer_bcc_unit_assert.svh"

module dbsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);
  import dbsf_pkg::*;

  logic at_frame_start;
  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // next output byte opens a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      at_frame_start <= 1'b1;
    end else if (out_xfer) begin
      at_frame_start <= m_axis_tuser;
    end
  end

  `DBSF_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_axis_tvalid)
  `DBSF_ASSERT(a_stall_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `DBSF_ASSERT(a_eof_ends_run, clk, rst, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
  `DBSF_ASSERT(a_frame_opens_dle, clk, rst,
    m_axis_tvalid && at_frame_start |-> m_axis_tdata == CHR_DLE && !m_axis_tlast)
  `DBSF_ASSERT(a_no_out_without_in, clk, rst,
    $past(rst) && !$past(in_xfer) |-> !m_axis_tvalid)

endmodule

bind dle_byte_stuffing_framer_bcc_unit dbsf_checker u_dbsf_checker (.*);

// ===== bench/tb_dle_byte_stuffing_framer_bcc_unit.sv =====
module tb_dle_byte_stuffing_framer_bcc_unit;
  import dbsf_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] payload_byte
  logic       s_axis_tlast = 1'b0;    // last_in_frame
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] line_byte
  logic       m_axis_tlast;           // end_of_run
  logic       m_axis_tuser;           // end_of_frame

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_run;
    logic       end_of_frame;
  } line_item_t;

  class framer_scoreboard;
    logic       frame_open;
    logic [7:0] check_accum;
    line_item_t expected_line_q[$];
    int         payload_count;
    int         frames_closed;
    int         dle_stuffed;

    function new();
      frame_open    = 1'b0;
      check_accum   = 8'h00;
      payload_count = 0;
      frames_closed = 0;
      dle_stuffed   = 0;
    endfunction

    function void push_line(logic [7:0] b, logic eor, logic eof);
      line_item_t item;
      item.line_byte    = b;
      item.end_of_run   = eor;
      item.end_of_frame = eof;
      expected_line_q.push_back(item);
    endfunction

    // predicts the line bytes produced by one accepted payload transfer
    function void note_payload(logic [7:0] data, logic last);
      payload_count++;
      if (!frame_open) begin
        push_line(CHR_DLE, 1'b0, 1'b0);
        push_line(CHR_STX, 1'b0, 1'b0);
        check_accum = 8'h00;
        frame_open  = 1'b1;
      end
      if (data == CHR_DLE) begin
        push_line(CHR_DLE, 1'b0, 1'b0);
        dle_stuffed++;
      end
      push_line(data, !last, 1'b0);
      check_accum = check_accum ^ data;
      if (last) begin
        push_line(CHR_DLE, 1'b0, 1'b0);
        push_line(CHR_ETX, 1'b0, 1'b0);
        push_line(check_accum ^ CHR_ETX, 1'b1, 1'b1);
        check_accum = 8'h00;
        frame_open  = 1'b0;
        frames_closed++;
      end
    endfunction

    // empty string when the line byte matches the oldest prediction
    function string check_line(logic [7:0] b, logic eor, logic eof);
      line_item_t want;
      string      msg;
      if (expected_line_q.size() == 0)
        return $sformatf("unexpected line byte %02h tlast=%0b tuser=%0b", b, eor, eof);
      want = expected_line_q.pop_front();
      msg = "";
      if (b !== want.line_byte)
        msg = {msg, $sformatf(" tdata got %02h exp %02h", b, want.line_byte)};
      if (eor !== want.end_of_run)
        msg = {msg, $sformatf(" tlast got %0b exp %0b", eor, want.end_of_run)};
      if (eof !== want.end_of_frame)
        msg = {msg, $sformatf(" tuser got %0b exp %0b", eof, want.end_of_frame)};
      if (msg != "")
        msg = {"line byte mismatch:", msg};
      return msg;
    endfunction

    function int pending();
      return expected_line_q.size();
    endfunction
  endclass

  framer_scoreboard sb;
  int mismatches = 0;
  int lines_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  dle_byte_stuffing_framer_bcc_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output monitor; values are stable between negedge and the next posedge
  initial begin
    string msg;
    forever begin
      @(negedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        msg = sb.check_line(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        if (msg != "")
          report_mismatch(msg);
        lines_seen++;
      end
    end
  end

  task automatic send_payload(logic [7:0] data, logic last);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      if (took)
        sb.note_payload(data, last);
      @(posedge clk);
    end while (!took);
  endtask

  task automatic set_idling(int send_pct, int recv_pct, int hold_cycles);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    send_idle_pct   = send_pct;
    recv_stall_pct  = recv_pct;
    hold_off_cycles = hold_cycles;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 20) return CHR_DLE;
    if (r < 26) return CHR_STX;
    if (r < 32) return CHR_ETX;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_frames(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++)
        send_payload(pick_payload(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-byte frames at the byte extremes and on DLE
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(CHR_DLE, 1'b1);
    // control characters as payload, back-to-back DLEs
    send_payload(CHR_STX, 1'b0);
    send_payload(CHR_ETX, 1'b0);
    send_payload(CHR_DLE, 1'b0);
    send_payload(CHR_DLE, 1'b0);
    send_payload(8'hAA, 1'b0);
    send_payload(8'h55, 1'b1);
    // DLE opens and closes a frame
    send_payload(CHR_DLE, 1'b0);
    send_payload(8'h01, 1'b0);
    send_payload(8'h80, 1'b0);
    send_payload(CHR_DLE, 1'b1);
    // check byte cancels to ETX ^ 0
    send_payload(8'h3C, 1'b0);
    send_payload(8'h3C, 1'b1);

    set_idling(0, 0, 0);
    send_random_frames(110);
    set_idling(84, 0, 0);
    send_random_frames(110);
    set_idling(0, 84, 0);
    send_random_frames(110);
    set_idling(17, 17, 0);
    send_random_frames(90);
    // receiver holds off while the sender keeps offering; input must back up
    set_idling(0, 0, 300);
    send_random_frames(30);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d payload bytes in %0d frames, %0d DLE bytes stuffed",
             sb.payload_count, sb.frames_closed, sb.dle_stuffed);
    $display("%0d line bytes checked under free-flowing, idle, stall and hold-off traffic",
             lines_seen);
    if (mismatches == 0) begin
      $display("tb_dle_byte_stuffing_framer_bcc_unit: done, clean");
    end else begin
      $display("tb_dle_byte_stuffing_framer_bcc_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout: %0d line bytes still expected", sb.pending());
    $display("tb_dle_byte_stuffing_framer_bcc_unit: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dbsf_pkg.sv
hdl/dbsf_front.sv
hdl/dbsf_queue.sv
hdl/dbsf_back.sv
hdl/dle_byte_stuffing_framer_bcc_unit.sv
hdl/dbsf_checker.sv
bench/tb_dle_byte_stuffing_framer_bcc_unit.sv
